>>> rtl/sadu_pkg.sv
// Shared types, constants and the arctangent table for the shelf/atan distortion unit.
`timescale 1ns / 1ps

package sadu_pkg;

    localparam int CNT_W     = 5;
    localparam int ATAN_LEN  = 24;
    localparam int Z_W       = 34;
    localparam int Q_W       = 31;
    localparam int DIV_STEPS = 3;
    localparam int REM_W     = 17;
    localparam int PT_W      = 46;
    localparam int PT_SH     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;

    localparam logic [REM_W-1:0] CLIP_DEN   = 17'd31415;
    localparam logic [REM_W-1:0] CLIP_DEN2  = 17'd62830;
    localparam logic [14:0]      CLIP_NUM   = 15'd20000;
    // floor(2^46 / 31415)
    localparam logic [31:0]      CLIP_RECIP = 32'd2239972757;

    // steps of the clip divide
    localparam logic [CNT_W-1:0] DIV_EST = 5'd0;
    localparam logic [CNT_W-1:0] DIV_REM = 5'd1;

    localparam logic [CFG_IDX_W-1:0] REG_SHELF_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHELF_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_AP_A,
        OP_AP_B,
        OP_AP_C,
        OP_SH_A,
        OP_SH_B,
        OP_DRV,
        OP_CORD,
        OP_TMUL,
        OP_DIV,
        OP_WET,
        OP_BL_A,
        OP_BL_B,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    function automatic logic [30:0] atan_q30(input logic [CNT_W-1:0] i);
        logic [30:0] v;
        case (i)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/sadu_ctrl.sv
// Sequencer for the shelf/atan distortion unit: steps the datapath through one sample.
`timescale 1ns / 1ps

module sadu_ctrl #(
    parameter int ATAN_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sadu_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_AP_A, S_AP_B, S_AP_C, S_SH_A, S_SH_B, S_DRV,
        S_CORD, S_TMUL, S_DIV, S_WET, S_BL_A, S_BL_B, S_OUT
    } t_state;

    t_state                     r_state;
    logic [sadu_pkg::CNT_W-1:0] r_cnt;
    logic                       r_out_valid;
    logic                       w_out_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd.idx = r_cnt;
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? sadu_pkg::OP_LOAD : sadu_pkg::OP_NONE;
            S_AP_A:  o_cmd.op = sadu_pkg::OP_AP_A;
            S_AP_B:  o_cmd.op = sadu_pkg::OP_AP_B;
            S_AP_C:  o_cmd.op = sadu_pkg::OP_AP_C;
            S_SH_A:  o_cmd.op = sadu_pkg::OP_SH_A;
            S_SH_B:  o_cmd.op = sadu_pkg::OP_SH_B;
            S_DRV:   o_cmd.op = sadu_pkg::OP_DRV;
            S_CORD:  o_cmd.op = sadu_pkg::OP_CORD;
            S_TMUL:  o_cmd.op = sadu_pkg::OP_TMUL;
            S_DIV:   o_cmd.op = sadu_pkg::OP_DIV;
            S_WET:   o_cmd.op = sadu_pkg::OP_WET;
            S_BL_A:  o_cmd.op = sadu_pkg::OP_BL_A;
            S_BL_B:  o_cmd.op = sadu_pkg::OP_BL_B;
            S_OUT:   o_cmd.op = w_out_load ? sadu_pkg::OP_OUT : sadu_pkg::OP_NONE;
            default: o_cmd.op = sadu_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_AP_A;
                    end
                end
                S_AP_A: r_state <= S_AP_B;
                S_AP_B: r_state <= S_AP_C;
                S_AP_C: r_state <= S_SH_A;
                S_SH_A: r_state <= S_SH_B;
                S_SH_B: r_state <= S_DRV;
                S_DRV: begin
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_cnt == sadu_pkg::CNT_W'(ATAN_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_TMUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_TMUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == sadu_pkg::CNT_W'(sadu_pkg::DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_WET;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WET:  r_state <= S_BL_A;
                S_BL_A: r_state <= S_BL_B;
                S_BL_B: r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/sadu_dp.sv
// Datapath of the shelf/atan distortion unit: shelf filter, CORDIC atan, scaling and blend.
`timescale 1ns / 1ps

module sadu_dp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sadu_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_we,
    input  logic [sadu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sadu_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic signed [SAMPLE_BITS-1:0]       o_sample
);

    localparam int N   = SAMPLE_BITS;
    localparam int YW  = N + 2;
    localparam int MW  = 16 + YW;
    localparam int AW  = N + 20;
    localparam int TW  = AW - 15;
    localparam int DW  = N + 3;
    localparam int PW  = 17 + DW;
    localparam int SSW = PW + 1;
    localparam int SW  = SSW - 13;
    localparam int GW  = 17 + SW;
    localparam int CW  = N + 28;
    localparam int ZW  = sadu_pkg::Z_W;
    localparam int QW  = sadu_pkg::Q_W;
    localparam int WPW = QW + N - 1;
    localparam int WMW = WPW - 22;
    localparam int WTW = WMW + 2;
    localparam int BW  = N + 29;
    localparam int RW  = BW - 24;

    localparam logic [N-2:0]           FULL_SCALE = {(N - 1){1'b1}};
    localparam logic signed [CW-1:0]   VX0 = CW'({1'b0, FULL_SCALE, 6'd0});
    localparam logic signed [TW-1:0]   Y_HI = TW'({1'b0, {(YW - 1){1'b1}}});
    localparam logic signed [TW-1:0]   Y_LO = -Y_HI - 1;
    localparam logic signed [RW-1:0]   R_HI = RW'({1'b0, {(N - 1){1'b1}}});
    localparam logic signed [RW-1:0]   R_LO = -R_HI - 1;

    logic signed [15:0]        r_coef;
    logic [15:0]               r_level;
    logic [15:0]               r_gain;
    logic [16:0]               r_mix;

    logic signed [N-1:0]       r_x;
    logic signed [N-1:0]       r_px;
    logic signed [YW-1:0]      r_py;
    logic signed [YW-1:0]      r_y;
    logic signed [AW-1:0]      r_acc;
    logic signed [PW-1:0]      r_prod;
    logic signed [SW-1:0]      r_s;
    logic signed [CW-1:0]      r_vx;
    logic signed [CW-1:0]      r_vy;
    logic signed [ZW-1:0]      r_z;
    logic                      r_neg;
    logic [sadu_pkg::PT_W-1:0] r_pt;
    logic [sadu_pkg::REM_W-1:0] r_rem;
    logic [QW-1:0]             r_q;
    logic signed [WTW-1:0]     r_wet;
    logic signed [BW-1:0]      r_bacc;
    logic signed [N-1:0]       r_out;

    logic signed [YW-1:0]      w_mop;
    logic signed [MW-1:0]      w_mprod;
    logic signed [AW-1:0]      w_abias;
    logic signed [TW-1:0]      w_atr;
    logic signed [YW-1:0]      w_ysat;
    logic signed [DW-1:0]      w_d;
    logic signed [16:0]        w_lv;
    logic signed [PW-1:0]      w_lprod;
    logic signed [SSW-1:0]     w_ssum;
    logic signed [SSW-1:0]     w_sbias;
    logic signed [GW-1:0]      w_gs;
    logic signed [CW-1:0]      w_sx;
    logic signed [CW-1:0]      w_sy;
    logic signed [ZW-1:0]      w_ang;
    logic signed [ZW-1:0]      w_zabs;
    logic [sadu_pkg::PT_W-1:0] w_pt;
    logic [63:0]               w_qprod;
    logic [QW+sadu_pkg::REM_W-1:0] w_qden;
    logic [sadu_pkg::REM_W-1:0] w_rem;
    logic [1:0]                w_qfix;
    logic [WPW-1:0]            w_wp;
    logic [WMW-1:0]            w_wm;
    logic [16:0]               w_mixc;
    logic signed [WTW+17:0]    w_wprod;
    logic signed [N+17:0]      w_dprod;
    logic signed [BW-1:0]      w_bbias;
    logic signed [RW-1:0]      w_rtr;
    logic signed [N-1:0]       w_rsat;

    assign o_sample = r_out;

    // allpass section
    assign w_mop   = (i_cmd.op == sadu_pkg::OP_AP_A) ? YW'(r_x) : r_py;
    assign w_mprod = r_coef * w_mop;
    assign w_abias = r_acc[AW-1] ? AW'(32767) : '0;
    assign w_atr   = TW'((r_acc + w_abias) >>> 15);
    assign w_ysat  = (w_atr > Y_HI) ? YW'(Y_HI) : (w_atr < Y_LO) ? YW'(Y_LO) : YW'(w_atr);

    // shelf mix
    assign w_d     = DW'(r_x) - DW'(r_y);
    assign w_lv    = $signed({1'b0, r_level}) - 17'sd4096;
    assign w_lprod = w_lv * w_d;
    assign w_ssum  = (SSW'(r_x) <<< 13) + SSW'(r_prod);
    assign w_sbias = w_ssum[SSW-1] ? SSW'(8191) : '0;
    assign w_gs    = $signed({1'b0, r_gain}) * r_s;

    // CORDIC
    assign w_sx  = r_vx >>> i_cmd.idx;
    assign w_sy  = r_vy >>> i_cmd.idx;
    assign w_ang = ZW'($signed({1'b0, sadu_pkg::atan_q30(i_cmd.idx)}));

    // clip scale; divide by a constant: reciprocal estimate (at most two low),
    // then remainder and correction
    assign w_zabs  = r_z[ZW-1] ? -r_z : r_z;
    assign w_pt    = w_zabs[QW-1:0] * sadu_pkg::CLIP_NUM;
    assign w_qprod = r_pt[sadu_pkg::PT_W-1:sadu_pkg::PT_SH] * sadu_pkg::CLIP_RECIP;
    assign w_qden  = r_q * sadu_pkg::CLIP_DEN;
    assign w_rem   = r_pt[sadu_pkg::REM_W-1:0] - w_qden[sadu_pkg::REM_W-1:0];
    assign w_qfix  = (r_rem >= sadu_pkg::CLIP_DEN2) ? 2'd2 :
                     (r_rem >= sadu_pkg::CLIP_DEN) ? 2'd1 : 2'd0;
    assign w_wp    = r_q * FULL_SCALE;
    assign w_wm    = w_wp[WPW-1:22];

    // blend
    assign w_mixc  = r_mix[16] ? 17'h10000 : r_mix;
    assign w_wprod = r_wet * $signed({1'b0, w_mixc});
    assign w_dprod = r_x * $signed({1'b0, 17'h10000 - w_mixc});
    assign w_bbias = r_bacc[BW-1] ? BW'(24'hFFFFFF) : '0;
    assign w_rtr   = RW'((r_bacc + w_bbias) >>> 24);
    assign w_rsat  = (w_rtr > R_HI) ? N'(R_HI) : (w_rtr < R_LO) ? N'(R_LO) : N'(w_rtr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= 16'sd22613;
            r_level <= 16'd1024;
            r_gain  <= 16'd4480;
            r_mix   <= 17'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sadu_pkg::REG_SHELF_COEF:  r_coef  <= i_cfg_wdata[15:0];
                sadu_pkg::REG_SHELF_LEVEL: r_level <= i_cfg_wdata[15:0];
                sadu_pkg::REG_DRIVE_GAIN:  r_gain  <= i_cfg_wdata[15:0];
                sadu_pkg::REG_WET_MIX:     r_mix   <= i_cfg_wdata;
                default:                   r_mix   <= r_mix;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
        end else if (i_cmd.op == sadu_pkg::OP_AP_C) begin
            r_px <= r_x;
            r_py <= w_ysat;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            sadu_pkg::OP_LOAD: r_x <= i_sample;
            sadu_pkg::OP_AP_A: r_acc <= AW'(w_mprod) - (AW'(r_px) <<< 15);
            sadu_pkg::OP_AP_B: r_acc <= r_acc + AW'(w_mprod);
            sadu_pkg::OP_AP_C: r_y <= w_ysat;
            sadu_pkg::OP_SH_A: r_prod <= w_lprod;
            sadu_pkg::OP_SH_B: r_s <= SW'((w_ssum + w_sbias) >>> 13);
            sadu_pkg::OP_DRV: begin
                r_vx <= VX0;
                r_vy <= CW'(w_gs);
                r_z  <= '0;
            end
            sadu_pkg::OP_CORD: begin
                if (!r_vy[CW-1] && (r_vy != '0)) begin
                    r_vx <= r_vx + w_sy;
                    r_vy <= r_vy - w_sx;
                    r_z  <= r_z + w_ang;
                end else if (r_vy[CW-1]) begin
                    r_vx <= r_vx - w_sy;
                    r_vy <= r_vy + w_sx;
                    r_z  <= r_z - w_ang;
                end
            end
            sadu_pkg::OP_TMUL: begin
                r_neg <= r_z[ZW-1];
                r_pt  <= w_pt;
            end
            sadu_pkg::OP_DIV: begin
                if (i_cmd.idx == sadu_pkg::DIV_EST) begin
                    r_q <= w_qprod[32+QW-1:32];
                end else if (i_cmd.idx == sadu_pkg::DIV_REM) begin
                    r_rem <= w_rem;
                end else begin
                    r_q <= r_q + QW'(w_qfix);
                end
            end
            sadu_pkg::OP_WET: r_wet <= r_neg ? -$signed({2'b00, w_wm}) : $signed({2'b00, w_wm});
            sadu_pkg::OP_BL_A: r_bacc <= BW'(w_wprod);
            sadu_pkg::OP_BL_B: r_bacc <= r_bacc + (BW'(w_dprod) <<< 8);
            sadu_pkg::OP_OUT: r_out <= w_rsat;
            default: r_out <= r_out;
        endcase
    end

endmodule

>>> rtl/shelf_atan_distortion_unit.sv
// Top level of the shelf/atan distortion unit: stream ports, sequencer and datapath.
`timescale 1ns / 1ps

// Usage:
//   Slave stream carries one signed sample per beat; master stream returns one
//   processed sample per beat. Config registers (0 shelf_coef, 1 shelf_level,
//   2 drive_gain, 3 wet_mix) are written through i_cfg_we/i_cfg_idx/i_cfg_wdata;
//   the user must write them only while the block is idle, as the block does not
//   enforce it. Writes take effect at once. Each sample passes a low-shelf
//   allpass, a drive multiply, a vectoring CORDIC atan, a clip scale (reciprocal
//   multiply with a remainder correction), and a dry/wet blend.
//   From input beat to output valid it passes six filter and drive steps,
//   the CORDIC iterations, four clip scale steps, three blend steps and the
//   output load. One sample is in flight at a time and the input reopens the
//   cycle after the output load.
//   The result sits in an output register; the next sample is accepted while it
//   waits. If the receiver stalls, the following result holds in the last step
//   until the output register frees.
//   Synchronous reset loads the register defaults and clears the filter history.

module shelf_atan_distortion_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int ATAN_STEPS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // in_sample
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,  // out_sample
    input  logic                                   i_cfg_we,
    input  logic [sadu_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [sadu_pkg::CFG_W-1:0]             i_cfg_wdata
);

    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

    sadu_pkg::t_cmd                w_cmd;
    logic signed [SAMPLE_BITS-1:0] w_out;

    sadu_ctrl #(
        .ATAN_STEPS(ATAN_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    sadu_dp #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_sample    (w_out)
    );

    assign m_axis_tdata = TDW'({{(TDW - SAMPLE_BITS){1'b0}}, w_out});

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a sample is in flight");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared right after input beat");

    a_ready_idle_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == sadu_pkg::OP_OUT |=> m_axis_tvalid && s_axis_tready)
        else $error("output load did not raise valid and return to idle");

endmodule

>>> bench/tb.sv
// Testbench for shelf_atan_distortion_unit: predicts each processed sample and checks the stream.
`timescale 1ns / 1ps

class distortion_scoreboard;
    longint coef, level, drive, mix;
    longint last_in, last_ap;
    logic [23:0] pending[$];
    int errors;
    longint atan_tbl[16] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                             16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                             262144, 131072, 65536, 32768};

    function new();
        errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        coef = 22613;
        level = 1024;
        drive = 4480;
        mix = 32768;
        last_in = 0;
        last_ap = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
        case (idx)
            sadu_pkg::REG_SHELF_COEF:  coef = longint'($signed(val[15:0]));
            sadu_pkg::REG_SHELF_LEVEL: level = longint'(val[15:0]);
            sadu_pkg::REG_DRIVE_GAIN:  drive = longint'(val[15:0]);
            sadu_pkg::REG_WET_MIX:     mix = longint'(val);
            default: ;
        endcase
    endfunction

    function longint clamp(longint v, int bits);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function void note_sample(logic [23:0] smp);
        longint fs, x, acc, y, s, vx, vy, nx, ny, z, t, wet, m, r;
        fs = 8388607;
        x = longint'($signed(smp));
        acc = coef * x - last_in * 32768 + coef * last_ap;
        y = clamp(acc / 32768, 26);
        last_in = x;
        last_ap = y;
        s = (x * 8192 + (level - 4096) * (x - y)) / 8192;
        vx = 64 * fs;
        vy = drive * s;
        z = 0;
        for (int i = 0; i < 16; i++) begin
            if (vy > 0) begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
                z += atan_tbl[i];
            end else if (vy < 0) begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
                z -= atan_tbl[i];
            end else begin
                nx = vx;
                ny = vy;
            end
            vx = nx;
            vy = ny;
        end
        t = z * 20000 / 31415;
        wet = t * fs / 64'sd4194304;
        m = (mix > 65536) ? 64'sd65536 : mix;
        acc = wet * m + x * 256 * (65536 - m);
        r = clamp(acc / 64'sd16777216, 24);
        pending.push_back(r[23:0]);
    endfunction

    function void check_result(logic [23:0] got);
        logic [23:0] exp_smp;
        if (pending.size() == 0) begin
            $error("out_sample: unexpected beat, got %0d", $signed(got));
            errors++;
            return;
        end
        exp_smp = pending.pop_front();
        if (got !== exp_smp) begin
            $error("out_sample: expected %0d, got %0d", $signed(exp_smp), $signed(got));
            errors++;
        end
    endfunction
endclass

module tb;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // in_sample
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;       // out_sample
    logic i_cfg_we = 1'b0;
    logic [sadu_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [sadu_pkg::CFG_W-1:0] i_cfg_wdata = '0;

    distortion_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;

    always #1 i_clk = ~i_clk;

    shelf_atan_distortion_unit u_top (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 4000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = $urandom_range(0, 1);
            2: m_axis_tready = ($urandom_range(0, 9) == 0);
            default: m_axis_tready = ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic send_sample(logic [23:0] smp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = smp;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(smp);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [sadu_pkg::CFG_IDX_W-1:0] idx,
                             logic [sadu_pkg::CFG_W-1:0] val);
        s_axis_tvalid = 1'b0;
        wait (sb.pending.size() == 0);
        repeat (100) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [23:0] rand_sample();
        logic [23:0] v;
        int bits;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: bits = $urandom_range(1, 23);
            1: bits = $urandom_range(8, 16);
            default: bits = 24;
        endcase
        if (bits < 24)
            v = 24'($signed(v[22:0] << (23 - bits)) >>> (23 - bits));
        return v;
    endfunction

    task automatic random_run(int n);
        repeat (n) send_sample(rand_sample());
    endtask

    initial begin
        logic [23:0] edges[12] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                                   24'h000001, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                                   24'h800000, 24'h7FFFFF, 24'h555555, 24'hAAAAAA};
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (edges[k]) send_sample(edges[k]);
        random_run(150);

        // extreme coefficients and levels
        write_cfg(sadu_pkg::REG_SHELF_COEF, 17'h08000);
        write_cfg(sadu_pkg::REG_SHELF_LEVEL, 17'h0FFFF);
        write_cfg(sadu_pkg::REG_DRIVE_GAIN, 17'd65535);
        write_cfg(sadu_pkg::REG_WET_MIX, 17'd65536);
        foreach (edges[k]) send_sample(edges[k]);
        random_run(150);

        write_cfg(sadu_pkg::REG_SHELF_COEF, 17'h07FFF);
        write_cfg(sadu_pkg::REG_SHELF_LEVEL, 17'd0);
        write_cfg(sadu_pkg::REG_WET_MIX, 17'h1FFFF);
        random_run(150);

        write_cfg(sadu_pkg::REG_DRIVE_GAIN, 17'd0);
        write_cfg(sadu_pkg::REG_SHELF_COEF, 17'd0);
        write_cfg(sadu_pkg::REG_WET_MIX, 17'd0);
        random_run(100);

        // shelf output of zero: coef 0 and zero input keep y at zero after the first zero sample
        write_cfg(sadu_pkg::REG_DRIVE_GAIN, 17'd64000);
        write_cfg(sadu_pkg::REG_WET_MIX, 17'd65536);
        repeat (5) send_sample(24'd0);
        random_run(100);

        repeat (8) begin
            write_cfg(sadu_pkg::REG_SHELF_COEF,
                      sadu_pkg::CFG_W'($urandom_range(0, 65535)) | 17'h10000);
            write_cfg(sadu_pkg::REG_SHELF_LEVEL, sadu_pkg::CFG_W'($urandom_range(0, 65535)));
            write_cfg(sadu_pkg::REG_DRIVE_GAIN, sadu_pkg::CFG_W'($urandom_range(0, 65535)));
            write_cfg(sadu_pkg::REG_WET_MIX, sadu_pkg::CFG_W'($urandom_range(0, 131071)));
            random_run(100);
        end

        s_axis_tvalid = 1'b0;
        wait (sb.pending.size() == 0);
        repeat (150) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

>>> filelist.f
rtl/sadu_pkg.sv
rtl/sadu_ctrl.sv
rtl/sadu_dp.sv
rtl/shelf_atan_distortion_unit.sv
bench/tb.sv
